// ===== sv/qfcp_pkg.sv =====
// shared types and constants of the quote feed character parser
package qfcp_pkg;

    // fixed widths of the result fields
    localparam int TEXT_BYTES = 16;
    localparam int CNT_W      = 5;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // character codes
    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_LOWER_Z = 8'd122;
    localparam logic [7:0] CH_DEL     = 8'd127;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_SEVEN   = 8'h37;

    // field tags
    localparam logic [7:0] TAG_NONE   = 8'h00;
    localparam logic [7:0] TAG_STAMP  = 8'h67; // g
    localparam logic [7:0] TAG_PREC   = 8'h66; // f
    localparam logic [7:0] TAG_BIDSZ  = 8'h6A; // j
    localparam logic [7:0] TAG_ASKSZ  = 8'h6B; // k
    localparam logic [7:0] TAG_TRADE  = 8'h74; // t
    localparam logic [7:0] TAG_TRDSZ  = 8'h69; // i
    localparam logic [7:0] TAG_ASK    = 8'h61; // a
    localparam logic [7:0] TAG_BID    = 8'h62; // b

    typedef enum logic [1:0] {
        FN_HDR_CHAR   = 2'd0,
        FN_MSG_CHAR   = 2'd1,
        FN_MSG_DELIM  = 2'd2,
        FN_PKT_DELIM  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CLS_LOWER,
        CLS_DEL,
        CLS_COMMA,
        CLS_OTHER
    } t_cls;

    typedef enum logic [2:0] {
        KIND_HEADER     = 3'd0,
        KIND_PRECISION  = 3'd1,
        KIND_BID_SIZE   = 3'd2,
        KIND_ASK_SIZE   = 3'd3,
        KIND_TRADE      = 3'd4,
        KIND_TRADE_SIZE = 3'd5,
        KIND_ASK        = 3'd6,
        KIND_BID        = 3'd7
    } t_kind;

    // classified input beat
    typedef struct packed {
        t_func      func;
        logic [7:0] ch;
        t_cls       cls;
    } t_item;

    // one result beat
    typedef struct packed {
        t_kind              kind;
        logic [63:0]        value_low;
        logic [63:0]        value_high;
        logic [CNT_W-1:0]   value_length;
        logic [63:0]        stamp_low;
        logic [63:0]        stamp_high;
        logic [CNT_W-1:0]   stamp_length;
        logic               truncated;
        logic               last;
    } t_res;

endpackage

// ===== sv/qfcp_if.sv =====
// channel interfaces: character input and parsed event output
interface qfcp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] ch;

    modport source(output valid, output func, output ch, input ready);
    modport sink(input valid, input func, input ch, output ready);
endinterface

interface qfcp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [63:0] value_low;
    logic [63:0] value_high;
    logic [4:0]  value_length;
    logic [63:0] stamp_low;
    logic [63:0] stamp_high;
    logic [4:0]  stamp_length;
    logic        truncated;
    logic        last;

    modport source(
        output valid, output kind, output value_low, output value_high,
        output value_length, output stamp_low, output stamp_high,
        output stamp_length, output truncated, output last, input ready
    );
    modport sink(
        input valid, input kind, input value_low, input value_high,
        input value_length, input stamp_low, input stamp_high,
        input stamp_length, input truncated, input last, output ready
    );
endinterface

// ===== sv/qfcp_front.sv =====
// front stage: takes input beats and classifies the character
module qfcp_front
    import qfcp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_func,
    input  logic [7:0] i_ch,
    output logic       o_valid,
    input  logic       i_ready,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;
    t_item w_item;
    logic  w_take;

    always_comb begin
        w_item.func = t_func'(i_func);
        w_item.ch   = i_ch;
        if (i_ch >= CH_LOWER_A && i_ch <= CH_LOWER_Z) begin
            w_item.cls = CLS_LOWER;
        end else if (i_ch == CH_DEL) begin
            w_item.cls = CLS_DEL;
        end else if (i_ch == CH_COMMA) begin
            w_item.cls = CLS_COMMA;
        end else begin
            w_item.cls = CLS_OTHER;
        end
    end

    assign o_in_ready = !r_valid || i_ready;
    assign w_take     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= w_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== sv/qfcp_queue.sv =====
// short fifo of classified beats between front and back
module qfcp_queue
    import qfcp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QPTR_W:0]    r_count;
    logic               w_push;
    logic               w_pop;

    assign o_ready = (r_count < (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + (QPTR_W+1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

// ===== sv/qfcp_back.sv =====
// back stage: parser state, text stores and two-slot result register
module qfcp_back
    import qfcp_pkg::*;
#(
    parameter int MAX_CHARS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_res  o_res
);

    localparam int IW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_CHARS);

    // text stores, no reset
    logic [7:0] r_hdr_text   [MAX_CHARS];
    logic [7:0] r_val_text   [MAX_CHARS];
    logic [7:0] r_code_text  [MAX_CHARS];
    logic [7:0] r_stamp_text [MAX_CHARS];

    // control state
    logic [CNT_W-1:0] r_hdr_count, n_hdr_count;
    logic             r_hdr_cut, n_hdr_cut;
    logic             r_hdr_done, n_hdr_done;
    logic             r_msg_open, n_msg_open;
    logic             r_head_done, n_head_done;
    logic             r_symbol, n_symbol;
    logic             r_field_open, n_field_open;
    logic [7:0]       r_tag, n_tag;
    logic [CNT_W-1:0] r_vcount, n_vcount;
    logic [CNT_W-1:0] r_ccount, n_ccount;
    logic [CNT_W-1:0] r_scount, n_scount;
    logic [2:0]       r_cut, n_cut; // bit 0 value, bit 1 code, bit 2 stamp

    // result slots
    t_res       r_slot0, n_slot0;
    t_res       r_slot1, n_slot1;
    logic [1:0] r_rcnt, n_rcnt;

    logic w_exec;
    logic w_take;
    logic do_hdr_app;
    logic do_val_app;
    logic do_swap;
    logic do_g77;
    logic do_close;
    logic do_open;
    logic emit_h;
    logic emit_f;
    logic cf_g77;
    logic cf_emit;
    t_kind cf_kind;

    logic [8*TEXT_BYTES-1:0] w_hdr_pack;
    logic [8*TEXT_BYTES-1:0] w_val_pack;
    logic [8*TEXT_BYTES-1:0] w_stamp_pack;
    t_res w_res_h;
    t_res w_res_f;

    // pack texts, bytes at and beyond the count read as zero
    for (genvar k = 0; k < TEXT_BYTES; k++) begin : g_pack
        if (k < MAX_CHARS) begin : g_on
            assign w_hdr_pack[8*k +: 8] =
                (r_hdr_count > CNT_W'(k)) ? r_hdr_text[k] : 8'd0;
            assign w_val_pack[8*k +: 8] =
                (r_vcount > CNT_W'(k)) ? r_val_text[k] : 8'd0;
            assign w_stamp_pack[8*k +: 8] =
                (r_scount > CNT_W'(k)) ? r_stamp_text[k] : 8'd0;
        end else begin : g_off
            assign w_hdr_pack[8*k +: 8]   = 8'd0;
            assign w_val_pack[8*k +: 8]   = 8'd0;
            assign w_stamp_pack[8*k +: 8] = 8'd0;
        end
    end

    assign w_take  = (r_rcnt != 2'd0) && i_ready;
    assign o_ready = (r_rcnt == 2'd0) || ((r_rcnt == 2'd1) && w_take);
    assign w_exec  = i_valid && o_ready;

    // what closing the open field would do
    always_comb begin
        cf_g77  = 1'b0;
        cf_emit = 1'b1;
        cf_kind = KIND_PRECISION;
        case (r_tag)
            TAG_STAMP: begin
                cf_emit = 1'b0;
                cf_g77  = (r_ccount == CNT_W'(2)) && (r_code_text[0] == CH_SEVEN)
                          && (r_code_text[1] == CH_SEVEN);
            end
            TAG_PREC:  cf_emit = (r_ccount == '0);
            TAG_BIDSZ: cf_kind = KIND_BID_SIZE;
            TAG_ASKSZ: cf_kind = KIND_ASK_SIZE;
            TAG_TRADE: cf_kind = KIND_TRADE;
            TAG_TRDSZ: cf_kind = KIND_TRADE_SIZE;
            TAG_ASK:   cf_kind = KIND_ASK;
            TAG_BID:   cf_kind = KIND_BID;
            default:   cf_emit = 1'b0;
        endcase
    end

    // step of the parser
    always_comb begin
        n_hdr_count  = r_hdr_count;
        n_hdr_cut    = r_hdr_cut;
        n_hdr_done   = r_hdr_done;
        n_msg_open   = r_msg_open;
        n_head_done  = r_head_done;
        n_symbol     = r_symbol;
        n_field_open = r_field_open;
        n_tag        = r_tag;
        n_vcount     = r_vcount;
        n_ccount     = r_ccount;
        n_scount     = r_scount;
        n_cut        = r_cut;
        do_hdr_app   = 1'b0;
        do_val_app   = 1'b0;
        do_swap      = 1'b0;
        do_g77       = 1'b0;
        do_close     = 1'b0;
        do_open      = 1'b0;
        emit_h       = 1'b0;
        emit_f       = 1'b0;

        if (w_exec) begin
            case (i_item.func)
                FN_HDR_CHAR: begin
                    if (r_hdr_count < MAXC) begin
                        do_hdr_app  = 1'b1;
                        n_hdr_count = r_hdr_count + CNT_W'(1);
                    end else begin
                        n_hdr_cut = 1'b1;
                    end
                end
                FN_MSG_CHAR: begin
                    if (!r_head_done) begin
                        if (i_item.cls == CLS_LOWER) begin
                            // prefix letter before any symbol char is ignored
                            if (r_symbol) begin
                                if (r_field_open) begin
                                    do_close = (r_vcount != '0);
                                    do_open  = (r_vcount != '0);
                                end else begin
                                    n_head_done = 1'b1;
                                    do_open     = 1'b1;
                                end
                            end
                        end else begin
                            n_symbol = 1'b1;
                        end
                    end else if (i_item.cls == CLS_LOWER || i_item.cls == CLS_DEL) begin
                        // delimiter on an empty value leaves the field as is
                        if (r_field_open) begin
                            do_close = (r_vcount != '0);
                            do_open  = (r_vcount != '0);
                        end else begin
                            do_open = 1'b1;
                        end
                    end else if (i_item.cls == CLS_COMMA) begin
                        do_swap  = 1'b1;
                        n_vcount = r_ccount;
                        n_ccount = r_vcount;
                        n_cut[0] = r_cut[1];
                        n_cut[1] = r_cut[0];
                    end else if (r_vcount < MAXC) begin
                        do_val_app = 1'b1;
                        n_vcount   = r_vcount + CNT_W'(1);
                    end else begin
                        n_cut[0] = 1'b1;
                    end
                end
                FN_MSG_DELIM: begin
                    if (!r_hdr_done) begin
                        emit_h     = 1'b1;
                        n_hdr_done = 1'b1;
                    end
                    do_close = r_field_open;
                    if (r_msg_open) begin
                        n_head_done = 1'b0;
                        n_symbol    = 1'b0;
                    end
                    n_msg_open = 1'b1;
                end
                FN_PKT_DELIM: begin
                    do_close = r_field_open;
                    if (r_msg_open) begin
                        n_msg_open  = 1'b0;
                        n_head_done = 1'b0;
                        n_symbol    = 1'b0;
                    end
                    n_hdr_count = '0;
                    n_hdr_cut   = 1'b0;
                    n_hdr_done  = 1'b0;
                end
                default: begin
                end
            endcase

            if (do_close) begin
                emit_f = cf_emit;
                if (cf_g77) begin
                    // value becomes the timestamp, with its cut flag
                    do_g77   = 1'b1;
                    n_scount = r_vcount;
                    n_cut[2] = r_cut[0];
                end
                n_tag        = TAG_NONE;
                n_vcount     = '0;
                n_ccount     = '0;
                n_cut[1:0]   = 2'b00;
                n_field_open = 1'b0;
            end
            if (do_open) begin
                n_tag        = i_item.ch;
                n_field_open = 1'b1;
            end
        end
    end

    // result beats, stamp is always the one before this step
    always_comb begin
        w_res_h.kind         = KIND_HEADER;
        w_res_h.value_low    = w_hdr_pack[63:0];
        w_res_h.value_high   = w_hdr_pack[127:64];
        w_res_h.value_length = r_hdr_count;
        w_res_h.stamp_low    = w_stamp_pack[63:0];
        w_res_h.stamp_high   = w_stamp_pack[127:64];
        w_res_h.stamp_length = r_scount;
        w_res_h.truncated    = r_hdr_cut || r_cut[2];
        w_res_h.last         = !emit_f;

        w_res_f.kind         = cf_kind;
        w_res_f.value_low    = w_val_pack[63:0];
        w_res_f.value_high   = w_val_pack[127:64];
        w_res_f.value_length = r_vcount;
        w_res_f.stamp_low    = w_stamp_pack[63:0];
        w_res_f.stamp_high   = w_stamp_pack[127:64];
        w_res_f.stamp_length = r_scount;
        w_res_f.truncated    = r_cut[0] || r_cut[2];
        w_res_f.last         = 1'b1;
    end

    always_comb begin
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        n_rcnt  = r_rcnt;
        if (w_exec) begin
            n_rcnt  = {1'b0, emit_h} + {1'b0, emit_f};
            n_slot0 = emit_h ? w_res_h : w_res_f;
            n_slot1 = w_res_f;
        end else if (w_take) begin
            n_slot0 = r_slot1;
            n_rcnt  = r_rcnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_count  <= '0;
            r_hdr_cut    <= 1'b0;
            r_hdr_done   <= 1'b0;
            r_msg_open   <= 1'b0;
            r_head_done  <= 1'b0;
            r_symbol     <= 1'b0;
            r_field_open <= 1'b0;
            r_tag        <= TAG_NONE;
            r_vcount     <= '0;
            r_ccount     <= '0;
            r_scount     <= '0;
            r_cut        <= '0;
            r_rcnt       <= 2'd0;
        end else begin
            r_hdr_count  <= n_hdr_count;
            r_hdr_cut    <= n_hdr_cut;
            r_hdr_done   <= n_hdr_done;
            r_msg_open   <= n_msg_open;
            r_head_done  <= n_head_done;
            r_symbol     <= n_symbol;
            r_field_open <= n_field_open;
            r_tag        <= n_tag;
            r_vcount     <= n_vcount;
            r_ccount     <= n_ccount;
            r_scount     <= n_scount;
            r_cut        <= n_cut;
            r_rcnt       <= n_rcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
        if (do_hdr_app) begin
            r_hdr_text[r_hdr_count[IW-1:0]] <= i_item.ch;
        end
        if (do_val_app) begin
            r_val_text[r_vcount[IW-1:0]] <= i_item.ch;
        end
        if (do_swap) begin
            r_val_text  <= r_code_text;
            r_code_text <= r_val_text;
        end
        if (do_g77) begin
            r_stamp_text <= r_val_text;
        end
    end

    assign o_valid = (r_rcnt != 2'd0);
    assign o_res   = r_slot0;

endmodule

// ===== sv/quote_feed_char_parser_core.sv =====
// top level of the quote feed character parser
//
//  channel  | dir | modport | payload                                        | beat when
//  ---------+-----+---------+------------------------------------------------+-------------------
//  i_in     | in  | sink    | func, ch                                       | valid && ready
//  o_out    | out | source  | kind, value_*, stamp_*, truncated, last        | valid && ready
//
//  one character beat per cycle is taken while the queue has room; the back executes
//  one beat per cycle while its result slots can accept it; a beat that yields two events
//  (header plus field) holds the result stage until both are taken, the four-entry
//  queue absorbs that; a beat passes front register, queue and result register
//  synchronous active-low reset clears control state; text stores are not reset
//  either side may stall at any time; input stalls only when the queue fills
module quote_feed_char_parser_core
    import qfcp_pkg::*;
#(
    parameter int MAX_CHARS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    qfcp_in_if.sink      i_in,
    qfcp_out_if.source   o_out
);

    // front to queue
    logic  w_fq_valid;
    logic  w_fq_ready;
    t_item w_fq_item;

    // queue to back
    logic  w_qb_valid;
    logic  w_qb_ready;
    t_item w_qb_item;

    // back result
    t_res  w_res;

    // classify each incoming character beat
    qfcp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_func     (i_in.func),
        .i_ch       (i_in.ch),
        .o_valid    (w_fq_valid),
        .i_ready    (w_fq_ready),
        .o_item     (w_fq_item)
    );

    // decouples the front from stalls of the result side
    qfcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fq_valid),
        .o_ready (w_fq_ready),
        .i_item  (w_fq_item),
        .o_valid (w_qb_valid),
        .i_ready (w_qb_ready),
        .o_item  (w_qb_item)
    );

    // parser state machine, text stores and result slots
    qfcp_back #(
        .MAX_CHARS (MAX_CHARS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qb_valid),
        .o_ready (w_qb_ready),
        .i_item  (w_qb_item),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (w_res)
    );

    // event beat fields
    assign o_out.kind         = w_res.kind;
    assign o_out.value_low    = w_res.value_low;
    assign o_out.value_high   = w_res.value_high;
    assign o_out.value_length = w_res.value_length;
    assign o_out.stamp_low    = w_res.stamp_low;
    assign o_out.stamp_high   = w_res.stamp_high;
    assign o_out.stamp_length = w_res.stamp_length;
    assign o_out.truncated    = w_res.truncated;
    assign o_out.last         = w_res.last;

endmodule
